### rtl/two_means_point_clustering_assert.svh
// Assertion macros for the two-means point clustering block
`ifndef TWO_MEANS_POINT_CLUSTERING_ASSERT_SVH
`define TWO_MEANS_POINT_CLUSTERING_ASSERT_SVH
// implication checked every clock outside reset
`define TMPC_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define TMPC_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

### rtl/tmpc_pkg.sv
// Package for the two-means point clustering block: types and constants
`timescale 1ns / 1ps
package tmpc_pkg;
   localparam int MaxPoints   = 1024;
   localparam int AddrW       = 10;
   localparam int CntW        = 11;
   localparam int CoordW      = 24;
   localparam int SumW        = 35;
   localparam int DistW       = 51;
   localparam int QuotW       = 35;
   localparam logic [3:0] PassReset = 4'd5;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT0,
      ST_INIT1,
      ST_INIT2,
      ST_PASS_RD,
      ST_PASS_RUN,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DIV_NEXT,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   typedef struct packed {
      logic             start;
      logic signed [SumW-1:0] dividend;
      logic [CntW-1:0]  divisor;
   } div_req_type;
endpackage

### rtl/tmpc_ram.sv
// Generic single-port-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module tmpc_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/tmpc_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module tmpc_div (
   input  logic                             clock,
   input  logic                             reset,
   input  tmpc_pkg::div_req_type            req,
   output logic                             done,
   output logic signed [tmpc_pkg::CoordW-1:0] quotient
);
   localparam int QW = tmpc_pkg::QuotW;
   localparam int CW = tmpc_pkg::CntW;
   localparam int StepW = $clog2(QW + 1);

   logic [QW-1:0]    quot_ff, quot_in;
   logic [CW:0]      rem_ff, rem_in;
   logic [CW-1:0]    dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [QW-1:0]    mag;
   logic [CW:0]      trial;
   logic [QW-1:0]    res;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mag = req.dividend[QW-1] ? QW'(-req.dividend) : QW'(req.dividend);
      trial = {rem_ff[CW-1:0], quot_ff[QW-1]};
      if (req.start) begin
         quot_in = mag;
         rem_in  = '0;
         dvs_in  = req.divisor;
         neg_in  = req.dividend[QW-1];
         step_in = StepW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   assign res      = neg_ff ? -quot_ff : quot_ff;
   assign done     = done_ff;
   assign quotient = res[tmpc_pkg::CoordW-1:0];
endmodule

### rtl/two_means_point_clustering.sv
// Top level of the two-means point clustering block
`timescale 1ns / 1ps
// Points are taken one per cycle while busy is low and written to a
// 1024-entry point memory; points beyond 1024 are dropped. The item flagged
// req_last_point starts the clustering, during which busy is high. With n
// stored points (n >= 2) the work is set by one memory read per point per
// pass, a pipeline drain and four divisions per pass (an empty cluster skips
// its two divisions); with n < 2 a single pass over one cluster is run.
// Centres then appear on rsp_ in index order, one per cycle under rsp_valid,
// and cannot be held off by the receiver.
module two_means_point_clustering (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_point_x,
   input  logic signed [23:0] req_point_y,
   input  logic               req_last_point,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_center_x,
   output logic signed [23:0] rsp_center_y,
   output logic [2:0]         rsp_center_index,
   output logic               rsp_last_center,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_wr_data
);
   localparam int AW = tmpc_pkg::AddrW;
   localparam int NW = tmpc_pkg::CntW;
   localparam int CW = tmpc_pkg::CoordW;
   localparam int SW = tmpc_pkg::SumW;
   localparam int DW = tmpc_pkg::DistW;

   tmpc_pkg::state_type state_ff, state_in;
   logic [3:0]  pass_cfg_ff;
   logic [NW-1:0] total_ff, total_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic        rd_valid_ff, rd_valid_in;
   logic [3:0]  pass_ff, pass_in;
   logic [1:0]  div_sel_ff, div_sel_in;
   logic        single_ff, single_in;
   logic signed [CW-1:0] cx_ff [2], cx_in [2];
   logic signed [CW-1:0] cy_ff [2], cy_in [2];
   logic signed [SW-1:0] sx_ff [2], sx_in [2];
   logic signed [SW-1:0] sy_ff [2], sy_in [2];
   logic [NW-1:0] cnt_ff [2], cnt_in [2];
   logic [DW-1:0] d0_ff, d1_ff;
   logic signed [CW-1:0] px_ff, py_ff;
   logic        acc_ff;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic signed [CW-1:0] rd_x, rd_y;
   tmpc_pkg::div_req_type div_req;
   logic          div_done;
   logic signed [CW-1:0] div_q;
   logic          accept;
   logic [NW-1:0] half;
   logic signed [CW:0] dx0, dy0, dx1, dy1;
   logic          best;

   assign accept = start && !busy;
   assign wr_en  = accept && (total_ff < NW'(tmpc_pkg::MaxPoints));
   assign half   = {1'b0, n_ff[NW-1:1]};

   tmpc_ram #(.Width(CW), .Depth(tmpc_pkg::MaxPoints)) u_ram_x (
      .clock, .wr_en, .wr_addr(total_ff[AW-1:0]), .wr_data(req_point_x),
      .rd_addr, .rd_data(rd_x));
   tmpc_ram #(.Width(CW), .Depth(tmpc_pkg::MaxPoints)) u_ram_y (
      .clock, .wr_en, .wr_addr(total_ff[AW-1:0]), .wr_data(req_point_y),
      .rd_addr, .rd_data(rd_y));

   tmpc_div u_div (.clock, .reset, .req(div_req), .done(div_done), .quotient(div_q));

   // distance pipeline stage on the point read last cycle
   assign dx0 = {rd_x[CW-1], rd_x} - {cx_ff[0][CW-1], cx_ff[0]};
   assign dy0 = {rd_y[CW-1], rd_y} - {cy_ff[0][CW-1], cy_ff[0]};
   assign dx1 = {rd_x[CW-1], rd_x} - {cx_ff[1][CW-1], cx_ff[1]};
   assign dy1 = {rd_y[CW-1], rd_y} - {cy_ff[1][CW-1], cy_ff[1]};
   assign best = d1_ff < d0_ff;

   always_ff @(posedge clock) begin
      if (reset) pass_cfg_ff <= tmpc_pkg::PassReset;
      else if (csr_wr_en) pass_cfg_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      d0_ff <= DW'(dx0 * dx0) + DW'(dy0 * dy0);
      d1_ff <= DW'(dx1 * dx1) + DW'(dy1 * dy1);
      px_ff <= rd_x;
      py_ff <= rd_y;
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      rd_valid_in = 1'b0;
      pass_in = pass_ff;
      div_sel_in = div_sel_ff;
      single_in = single_ff;
      cx_in = cx_ff; cy_in = cy_ff;
      sx_in = sx_ff; sy_in = sy_ff; cnt_in = cnt_ff;
      rd_addr = idx_ff[AW-1:0];
      div_req.start = 1'b0;
      div_req.divisor = cnt_ff[div_sel_ff[1]];
      div_req.dividend = div_sel_ff[0] ? sy_ff[div_sel_ff[1]] : sx_ff[div_sel_ff[1]];
      rsp_valid = 1'b0;
      rsp_center_x = cx_ff[0];
      rsp_center_y = cy_ff[0];
      rsp_center_index = 3'd0;
      rsp_last_center = 1'b0;
      busy = 1'b1;

      // accumulate the point whose distances were registered last cycle
      if (acc_ff) begin
         if (single_ff || !best) begin
            sx_in[0] = sx_ff[0] + SW'(px_ff);
            sy_in[0] = sy_ff[0] + SW'(py_ff);
            cnt_in[0] = cnt_ff[0] + 1'b1;
         end else begin
            sx_in[1] = sx_ff[1] + SW'(px_ff);
            sy_in[1] = sy_ff[1] + SW'(py_ff);
            cnt_in[1] = cnt_ff[1] + 1'b1;
         end
      end

      case (state_ff)
         tmpc_pkg::ST_LOAD: begin
            busy = 1'b0;
            if (accept) begin
               if (wr_en) total_in = total_ff + 1'b1;
               if (req_last_point) begin
                  n_in = wr_en ? total_ff + 1'b1 : total_ff;
                  total_in = '0;
                  state_in = tmpc_pkg::ST_INIT0;
               end
            end
         end
         tmpc_pkg::ST_INIT0: begin
            for (int k = 0; k < 2; k++) begin
               sx_in[k] = '0; sy_in[k] = '0; cnt_in[k] = '0;
            end
            idx_in = '0;
            if (n_ff < NW'(2)) begin
               single_in = 1'b1;
               cx_in[0] = '0; cy_in[0] = '0;
               pass_in = 4'd1;
               state_in = tmpc_pkg::ST_PASS_RD;
            end else begin
               single_in = 1'b0;
               rd_addr = '0;
               state_in = tmpc_pkg::ST_INIT1;
            end
         end
         tmpc_pkg::ST_INIT1: begin
            cx_in[0] = rd_x; cy_in[0] = rd_y;
            rd_addr = half[AW-1:0];
            state_in = tmpc_pkg::ST_INIT2;
         end
         tmpc_pkg::ST_INIT2: begin
            cx_in[1] = rd_x; cy_in[1] = rd_y;
            pass_in = pass_cfg_ff;
            idx_in = '0;
            state_in = (pass_cfg_ff == 4'd0) ? tmpc_pkg::ST_EMIT0 : tmpc_pkg::ST_PASS_RD;
         end
         tmpc_pkg::ST_PASS_RD: begin
            if (idx_ff < n_ff) begin
               rd_valid_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!rd_valid_ff && !acc_ff) begin
               div_sel_in = 2'd0;
               state_in = tmpc_pkg::ST_DIV_START;
            end
         end
         tmpc_pkg::ST_DIV_START: begin
            if (cnt_ff[div_sel_ff[1]] == '0) begin
               state_in = tmpc_pkg::ST_DIV_NEXT;
            end else begin
               div_req.start = 1'b1;
               state_in = tmpc_pkg::ST_DIV_RUN;
            end
         end
         tmpc_pkg::ST_DIV_RUN: begin
            if (div_done) begin
               if (div_sel_ff[0]) cy_in[div_sel_ff[1]] = div_q;
               else cx_in[div_sel_ff[1]] = div_q;
               state_in = tmpc_pkg::ST_DIV_NEXT;
            end
         end
         tmpc_pkg::ST_DIV_NEXT: begin
            div_sel_in = div_sel_ff + 1'b1;
            if (div_sel_ff == 2'd3 || (single_ff && div_sel_ff == 2'd1)) begin
               for (int k = 0; k < 2; k++) begin
                  sx_in[k] = '0; sy_in[k] = '0; cnt_in[k] = '0;
               end
               idx_in = '0;
               pass_in = pass_ff - 1'b1;
               state_in = (pass_ff == 4'd1) ? tmpc_pkg::ST_EMIT0 : tmpc_pkg::ST_PASS_RD;
            end else begin
               state_in = tmpc_pkg::ST_DIV_START;
            end
         end
         tmpc_pkg::ST_EMIT0: begin
            rsp_valid = 1'b1;
            rsp_last_center = single_ff;
            state_in = single_ff ? tmpc_pkg::ST_LOAD : tmpc_pkg::ST_EMIT1;
         end
         tmpc_pkg::ST_EMIT1: begin
            rsp_valid = 1'b1;
            rsp_center_x = cx_ff[1];
            rsp_center_y = cy_ff[1];
            rsp_center_index = 3'd1;
            rsp_last_center = 1'b1;
            state_in = tmpc_pkg::ST_LOAD;
         end
         default: state_in = tmpc_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tmpc_pkg::ST_LOAD;
         total_ff    <= '0;
         rd_valid_ff <= 1'b0;
         acc_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         rd_valid_ff <= rd_valid_in;
         acc_ff      <= rd_valid_ff;
      end
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      pass_ff    <= pass_in;
      div_sel_ff <= div_sel_in;
      single_ff  <= single_in;
      cx_ff <= cx_in; cy_ff <= cy_in;
      sx_ff <= sx_in; sy_ff <= sy_in; cnt_ff <= cnt_in;
   end
endmodule

### rtl/tmpc_checker.sv
// Port-level checker for the two-means point clustering block, with its bind
`timescale 1ns / 1ps
`include "two_means_point_clustering_assert.svh"
module tmpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_last_point,
   input logic       rsp_valid,
   input logic [2:0] rsp_center_index,
   input logic       rsp_last_center
);
   `TMPC_ASSERT_NXT(a_last_starts_work, clock, reset, start && !busy && req_last_point, busy)
   `TMPC_ASSERT_IMP(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `TMPC_ASSERT_NXT(a_idle_after_last, clock, reset, rsp_valid && rsp_last_center, !busy)
   `TMPC_ASSERT_NXT(a_second_follows, clock, reset, rsp_valid && !rsp_last_center,
      rsp_valid && rsp_center_index == 3'd1 && rsp_last_center)
endmodule

bind two_means_point_clustering tmpc_checker u_tmpc_checker (
   .clock, .reset, .start, .busy, .req_last_point, .rsp_valid,
   .rsp_center_index, .rsp_last_center);
